### rtl/core/dpr_pkg.sv
// Package for the disparity reprojection block: payload structs, register indexes.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dpr_pkg;
    typedef struct packed {
        logic [10:0] column;
        logic [10:0] row;
        logic [7:0]  disparity;
        logic [23:0] pixel_bgr;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [23:0]        point_rgb;
        logic               depth_fault;
    } t_point;

    localparam logic [2:0] REG_X_OFFSET     = 3'd0;
    localparam logic [2:0] REG_Y_OFFSET     = 3'd1;
    localparam logic [2:0] REG_FOCAL        = 3'd2;
    localparam logic [2:0] REG_INV_BASELINE = 3'd3;
    localparam logic [2:0] REG_W_OFFSET     = 3'd4;

    localparam int FRAC_BITS = 16;

    // Divider lane word: magnitudes of three numerators, remainders, quotients.
    localparam int DIV_W = 41;
    localparam int QB    = 33 + FRAC_BITS;

    typedef struct packed {
        logic              vld;
        logic              wzero;
        logic [DIV_W-1:0]  den;
        logic              wneg;
        logic [2:0]        nneg;
        logic [2:0]        nzero;
        logic [3*QB-1:0]   rem;
        logic [3*QB-1:0]   num;
        logic [3*QB-1:0]   quo;
        logic [23:0]       rgb;
    } t_lane;
endpackage
`default_nettype wire

### rtl/core/dpr_div_cell.sv
// One restoring-division cell: retires one quotient bit of three parallel quotients.
// Depends on dpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dpr_div_cell (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire dpr_pkg::t_lane i_lane,
    output dpr_pkg::t_lane    o_lane
);
    import dpr_pkg::*;

    t_lane r_lane;
    t_lane n_lane;
    logic [QB:0] w_trial;
    logic [QB-1:0] w_rem;

    always_comb begin
        n_lane = i_lane;
        for (int k = 0; k < 3; k++) begin
            w_rem   = i_lane.rem[k*QB +: QB];
            w_trial = {w_rem, i_lane.num[k*QB + QB-1]} - {{(QB-DIV_W+1){1'b0}}, i_lane.den};
            n_lane.num[k*QB +: QB] = {i_lane.num[k*QB +: QB-1], 1'b0};
            if (!w_trial[QB]) begin
                n_lane.rem[k*QB +: QB] = w_trial[QB-1:0];
                n_lane.quo[k*QB +: QB] = {i_lane.quo[k*QB +: QB-1], 1'b1};
            end else begin
                n_lane.rem[k*QB +: QB] = {w_rem[QB-2:0], i_lane.num[k*QB + QB-1]};
                n_lane.quo[k*QB +: QB] = {i_lane.quo[k*QB +: QB-1], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule
`default_nettype wire

### rtl/core/disparity_to_point_reprojection.sv
// Disparity reprojection: one pixel in, one saturated Q16.16 point out per cycle unless
// the output is held; pixels with zero disparity give no point. A front stage forms w and
// the numerators, a chain of 49 divider cells retires one quotient bit each for x, y and z,
// and a back stage signs and saturates. One pixel is accepted every cycle, and the whole
// chain stalls only while the output register is held. Depends on dpr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module disparity_to_point_reprojection (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire dpr_pkg::t_pixel i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output dpr_pkg::t_point      o_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [31:0]     i_cfg_data
);
    import dpr_pkg::*;

    logic signed [31:0] r_qx, r_qy, r_qf, r_qb, r_qw;
    logic en;
    t_lane r_front;
    t_lane lanes [0:QB];
    t_point r_out;
    logic r_out_vld;

    assign en = !r_out_vld || i_ready;
    assign o_ready = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0; r_qy <= '0; r_qf <= 32'sd65536;
            r_qb <= 32'sd65536; r_qw <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_X_OFFSET:     r_qx <= i_cfg_data;
                REG_Y_OFFSET:     r_qy <= i_cfg_data;
                REG_FOCAL:        r_qf <= i_cfg_data;
                REG_INV_BASELINE: r_qb <= i_cfg_data;
                REG_W_OFFSET:     r_qw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [41:0] w_w, w_wmag;
    logic signed [43:0] w_n [0:2];
    logic [QB-1:0] w_nmag [0:2];
    t_lane n_front;

    always_comb begin
        w_w = $signed({1'b0, i_data.disparity}) * r_qb + 42'(r_qw);
        w_wmag = w_w[41] ? -w_w : w_w;
        w_n[0] = ($signed({1'b0, i_data.column}) <<< FRAC_BITS) + 44'(r_qx);
        w_n[1] = ($signed({1'b0, i_data.row}) <<< FRAC_BITS) + 44'(r_qy);
        w_n[2] = 44'(r_qf);
        n_front = '0;
        n_front.vld = i_valid && i_data.disparity != 8'd0;
        n_front.wzero = w_w == 42'sd0;
        n_front.den = w_wmag[DIV_W-1:0];
        n_front.wneg = w_w[41];
        n_front.rgb = i_data.pixel_bgr;
        for (int k = 0; k < 3; k++) begin
            n_front.nneg[k] = w_n[k][43];
            n_front.nzero[k] = w_n[k] == 44'sd0;
            w_nmag[k] = QB'(w_n[k][43] ? -w_n[k] : w_n[k]) << FRAC_BITS;
            n_front.num[k*QB +: QB] = w_nmag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.vld <= 1'b0;
        end else if (en) begin
            r_front <= n_front;
        end
    end

    assign lanes[0] = r_front;
    for (genvar g = 0; g < QB; g++) begin : g_cell
        dpr_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_lane(lanes[g]), .o_lane(lanes[g+1])
        );
    end

    t_lane w_last;
    t_point n_out;
    logic [QB-1:0] w_q;
    logic [31:0] w_res;
    logic w_f;
    always_comb begin
        w_last = lanes[QB];
        n_out = '0;
        n_out.point_rgb = w_last.rgb;
        w_f = w_last.wzero;
        for (int k = 0; k < 3; k++) begin
            w_q = w_last.quo[k*QB +: QB];
            if (w_last.wzero) begin
                w_res = w_last.nzero[k] ? 32'h0 :
                        (w_last.nneg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF);
            end else if (w_last.nneg[k] ^ w_last.wneg) begin
                if (w_q > QB'(33'h8000_0000)) begin
                    w_res = 32'h8000_0000; w_f = 1'b1;
                end else begin
                    w_res = 32'(-w_q);
                end
            end else begin
                if (w_q > QB'(33'h7FFF_FFFF)) begin
                    w_res = 32'h7FFF_FFFF; w_f = 1'b1;
                end else begin
                    w_res = w_q[31:0];
                end
            end
            case (k)
                0: n_out.point_x = w_res;
                1: n_out.point_y = w_res;
                default: n_out.point_z = w_res;
            endcase
        end
        n_out.depth_fault = w_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_last.vld;
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data = r_out;
endmodule
`default_nettype wire

### tb/disparity_to_point_reprojection_tb.sv
// Testbench for disparity_to_point_reprojection: drives pixel words and register writes,
// predicts each point in Q16.16 and checks it field by field against the block.
// Depends on dpr_pkg and the block itself.
`timescale 1ns / 1ps
module disparity_to_point_reprojection_tb;
    import dpr_pkg::*;

    localparam int FRAC = 16;
    localparam int PIPE_CYCLES = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_pixel i_data;
    logic o_valid;
    logic i_ready;
    t_point o_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    logic signed [31:0] mat_q [0:4];
    t_point expected_points [$];
    int error_count;
    int pixels_sent;
    int points_seen;
    int faults_seen;
    int send_idle_pct;
    int recv_stall_pct;

    disparity_to_point_reprojection DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("disparity_to_point_reprojection verification failed");
        $finish;
    end

    function automatic logic signed [31:0] divide_saturated(
        input logic signed [63:0] num, input logic signed [63:0] w, inout logic fault);
        logic signed [63:0] q;
        if (w == 0) begin
            fault = 1'b1;
            if (num > 0) return 32'sh7fffffff;
            if (num < 0) return 32'sh80000000;
            return 0;
        end
        q = (num <<< FRAC) / w;
        if (q > 64'sh7fffffff) begin
            fault = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -64'sh80000000) begin
            fault = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    function automatic void project_pixel(input t_pixel px);
        logic signed [63:0] w;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic fault;
        t_point pt;
        if (px.disparity == 0) return;
        fault = 1'b0;
        w = $signed({56'd0, px.disparity}) * 64'(mat_q[REG_INV_BASELINE])
            + 64'(mat_q[REG_W_OFFSET]);
        nx = ($signed({53'd0, px.column}) <<< FRAC) + 64'(mat_q[REG_X_OFFSET]);
        ny = ($signed({53'd0, px.row}) <<< FRAC) + 64'(mat_q[REG_Y_OFFSET]);
        pt.point_x = divide_saturated(nx, w, fault);
        pt.point_y = divide_saturated(ny, w, fault);
        pt.point_z = divide_saturated(64'(mat_q[REG_FOCAL]), w, fault);
        pt.point_rgb = {px.pixel_bgr[23:16], px.pixel_bgr[15:8], px.pixel_bgr[7:0]};
        pt.depth_fault = fault;
        expected_points = {expected_points, pt};
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && o_valid && i_ready) begin
            t_point exp_pt;
            points_seen++;
            if (expected_points.size() == 0) begin
                $error("point with no pixel pending: %p", o_data);
                error_count++;
            end else begin
                exp_pt = expected_points.pop_front();
                if (exp_pt.depth_fault) faults_seen++;
                if (o_data.point_x !== exp_pt.point_x) begin
                    $error("point_x expected %0d got %0d", exp_pt.point_x, o_data.point_x);
                    error_count++;
                end
                if (o_data.point_y !== exp_pt.point_y) begin
                    $error("point_y expected %0d got %0d", exp_pt.point_y, o_data.point_y);
                    error_count++;
                end
                if (o_data.point_z !== exp_pt.point_z) begin
                    $error("point_z expected %0d got %0d", exp_pt.point_z, o_data.point_z);
                    error_count++;
                end
                if (o_data.point_rgb !== exp_pt.point_rgb) begin
                    $error("point_rgb expected %h got %h", exp_pt.point_rgb, o_data.point_rgb);
                    error_count++;
                end
                if (o_data.depth_fault !== exp_pt.depth_fault) begin
                    $error("depth_fault expected %b got %b",
                           exp_pt.depth_fault, o_data.depth_fault);
                    error_count++;
                end
            end
        end
    end

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        project_pixel(px);
        pixels_sent++;
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_matrix(input logic [2:0] idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= REG_W_OFFSET) mat_q[idx] = value;
    endtask

    task automatic write_all(input logic [31:0] xo, input logic [31:0] yo,
                             input logic [31:0] fo, input logic [31:0] ib,
                             input logic [31:0] wo);
        drain_pipeline();
        write_matrix(REG_X_OFFSET, xo);
        write_matrix(REG_Y_OFFSET, yo);
        write_matrix(REG_FOCAL, fo);
        write_matrix(REG_INV_BASELINE, ib);
        write_matrix(REG_W_OFFSET, wo);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_pixel random_pixel(input bit allow_zero);
        t_pixel px;
        px.column = 11'($urandom);
        px.row = 11'($urandom);
        px.disparity = allow_zero ? 8'($urandom) : 8'($urandom_range(255, 1));
        px.pixel_bgr = 24'($urandom);
        return px;
    endfunction

    task automatic test_reset_defaults();
        send_pixel('{11'd0, 11'd0, 8'd1, 24'h000000});
        send_pixel('{11'd2047, 11'd2047, 8'd255, 24'hffffff});
        send_pixel('{11'd100, 11'd50, 8'd0, 24'h123456});
        send_pixel('{11'd640, 11'd480, 8'd1, 24'habcdef});
    endtask

    task automatic test_zero_w();
        write_all(32'h0001_0000, 32'hffff_0000, 32'h0000_0000, 32'd0, 32'd0);
        send_pixel('{11'd5, 11'd5, 8'd7, 24'h010203});
        send_pixel('{11'd0, 11'd1, 8'd255, 24'h0a0b0c});
        write_all(32'h8000_0000, 32'd0, 32'h8000_0000, 32'h0001_0000, 32'hfff0_0000);
        send_pixel('{11'd0, 11'd0, 8'd16, 24'h555555});
        send_pixel('{11'd2047, 11'd0, 8'd16, 24'haaaaaa});
    endtask

    task automatic test_overflow();
        write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'd0);
        send_pixel('{11'd2047, 11'd2047, 8'd1, 24'hff0000});
        send_pixel('{11'd0, 11'd0, 8'd255, 24'h00ff00});
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000);
        send_pixel('{11'd0, 11'd0, 8'd255, 24'h0000ff});
        send_pixel('{11'd2047, 11'd2047, 8'd1, 24'h808080});
        write_all(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pixel('{11'd1, 11'd2, 8'd255, 24'h7f7f7f});
        send_pixel('{11'd1024, 11'd1024, 8'd128, 24'h000001});
    endtask

    task automatic test_ignored_index();
        drain_pipeline();
        write_matrix(3'd5, $urandom);
        write_matrix(3'd7, $urandom);
        i_cfg_valid <= 1'b0;
        send_pixel('{11'd3, 11'd4, 8'd2, 24'hfedcba});
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        drain_pipeline();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        case ($urandom_range(2))
            0: write_all(32'hfd80_0000, 32'hfe20_0000, 32'h0200_0000, 32'h0000_1000, 32'd0);
            1: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            default: write_all($urandom_range(65535) << 8, $urandom, $urandom_range(255) << 16,
                               $urandom_range(65535), $urandom_range(255));
        endcase
        repeat (count) send_pixel(random_pixel($urandom_range(9) == 0));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        error_count = 0;
        pixels_sent = 0;
        points_seen = 0;
        faults_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mat_q[0] = 0;
        mat_q[1] = 0;
        mat_q[2] = 32'sd65536;
        mat_q[3] = 32'sd65536;
        mat_q[4] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_zero_w();
        test_overflow();
        test_ignored_index();
        for (int k = 0; k < 3; k++) begin
            test_random_phase(0, 0, 40);
            test_random_phase(57, 0, 40);
            test_random_phase(0, 57, 40);
            test_random_phase(12, 12, 30);
        end
        drain_pipeline();

        $display("Sent %0d pixels, checked %0d points, %0d with depth fault.",
                 pixels_sent, points_seen, faults_seen);
        $display("Covered reset matrix, zero w, saturation, ignored indexes and random stalls.");
        if (error_count == 0) begin
            $display("disparity_to_point_reprojection verification clean");
        end else begin
            $display("disparity_to_point_reprojection verification failed");
        end
        $finish;
    end
endmodule
